[rtl/ssfp_pkg.sv]
// Shared types and constants for the size-sorted free region pool.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package ssfp_pkg;

  localparam int POOL_DEPTH = 64;

  localparam int SIZE_W   = 40;
  localparam int ADDR_W   = 48;
  localparam int REGION_W = 16;
  localparam int JOB_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   address;
    logic [REGION_W-1:0] region;
    logic [JOB_W-1:0]    job;
  } entry_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic   cmp;    // evaluate the size compare and hold the flag
    logic   act;    // apply the shift chosen by the flags
    logic   alloc;  // current command is an allocate
    entry_t item;   // current region (size doubles as the request on allocate)
  } ctl_t;

endpackage

`default_nettype wire

[rtl/ssfp_if.sv]
// Valid/ready channel interfaces for requests and results of the free region pool.
// Depends on ssfp_pkg for field widths.
`default_nettype none

interface ssfp_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [ssfp_pkg::SIZE_W-1:0]        region_size;
  logic [ssfp_pkg::ADDR_W-1:0]        base_address;
  logic [ssfp_pkg::REGION_W-1:0]      region_number;
  logic [ssfp_pkg::JOB_W-1:0]         owner_job;

  modport source (output valid, cmd, region_size, base_address, region_number, owner_job,
                  input ready);
  modport sink   (input valid, cmd, region_size, base_address, region_number, owner_job,
                  output ready);
endinterface

interface ssfp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ssfp_pkg::STATUS_W-1:0]      status;
  logic [ssfp_pkg::SIZE_W-1:0]        granted_size;
  logic [ssfp_pkg::ADDR_W-1:0]        granted_address;
  logic [ssfp_pkg::REGION_W-1:0]      granted_region;
  logic [ssfp_pkg::JOB_W-1:0]         granted_job;
  logic [ssfp_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, status, granted_size, granted_address, granted_region,
                  granted_job, entry_count, input ready);
  modport sink   (input valid, status, granted_size, granted_address, granted_region,
                  granted_job, entry_count, output ready);
endinterface

`default_nettype wire

[rtl/size_sorted_free_region_pool.sv]
// Top level of the size-sorted free region pool: sequencer, count, result register.
// Depends on ssfp_pkg, ssfp_if (ssfp_req_if, ssfp_rsp_if) and ssfp_cell.
`default_nettype none

// Best-fit free list held in a chain of Depth cells, kept sorted by ascending size.
// An add request inserts the region ahead of the first strictly larger entry (equal
// sizes keep arrival order); when all Depth cells are used the region is dropped and
// status reports table full. An allocate request removes and returns the smallest
// entry whose size is at least the requested size, or reports no fit and leaves the
// table unchanged. Every result carries the entry count after the request. Each
// request passes through a compare step, in which every cell compares its size against
// the request and holds a flag, and a shift step, in which the cells shift from their
// neighbors as the flags direct and the result is loaded into the output register.
// A new request is taken in the shift step, so requests overlap as long as results
// are drained; a result left waiting holds the following request in its shift step.
// There is no clearing pass after reset: cells past the count are ignored, so the
// block takes requests as soon as reset is released.
module size_sorted_free_region_pool #(
  parameter int Depth = ssfp_pkg::POOL_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  ssfp_req_if.sink         req,
  ssfp_rsp_if.source       rsp
);

  localparam int CountW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    IDLE,
    CMP,
    ACT
  } state_t;

  state_t                  state;
  logic [CountW-1:0]       held_count;
  logic                    cur_cmd;
  ssfp_pkg::entry_t        cur_item;

  ssfp_pkg::ctl_t          ctl;
  logic [Depth-1:0]        occ;
  logic [Depth-1:0]        flags;
  ssfp_pkg::entry_t        entries [Depth];
  ssfp_pkg::entry_t        grants  [Depth];
  ssfp_pkg::entry_t        grant_or;

  logic                    accept;
  logic                    emit;
  logic                    full;
  logic                    any_fit;
  logic                    apply;

  // ---------------------------------------------------------------------------
  // Handshake and control
  // ---------------------------------------------------------------------------
  assign full    = (held_count == CountW'(Depth));
  assign any_fit = |flags;
  assign emit    = (state == ACT) && (!rsp.valid || rsp.ready);
  assign apply   = emit && ((cur_cmd == ssfp_pkg::CMD_ALLOC) ? any_fit : !full);

  // take the next request while the current one finishes its shift cycle
  assign req.ready = (state == IDLE) || emit;
  assign accept    = req.valid && req.ready;

  assign ctl.cmp   = (state == CMP);
  assign ctl.act   = apply;
  assign ctl.alloc = (cur_cmd == ssfp_pkg::CMD_ALLOC);
  assign ctl.item  = cur_item;

  // ---------------------------------------------------------------------------
  // Chain of cells
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign occ[i] = (CountW'(i) < held_count);

    if (i == 0) begin : g_head
      if (Depth > 1) begin : g_more
        ssfp_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .occupied   (occ[i]),
          .prev_flag  (1'b0),
          .prev_entry (cur_item),
          .next_entry (entries[i+1]),
          .flag       (flags[i]),
          .entry      (entries[i]),
          .grant      (grants[i])
        );
      end else begin : g_one
        ssfp_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .occupied   (occ[i]),
          .prev_flag  (1'b0),
          .prev_entry (cur_item),
          .next_entry (entries[i]),
          .flag       (flags[i]),
          .entry      (entries[i]),
          .grant      (grants[i])
        );
      end
    end else if (i == Depth - 1) begin : g_tail
      ssfp_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ[i]),
        .prev_flag  (flags[i-1]),
        .prev_entry (entries[i-1]),
        .next_entry (entries[i]),
        .flag       (flags[i]),
        .entry      (entries[i]),
        .grant      (grants[i])
      );
    end else begin : g_mid
      ssfp_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occ[i]),
        .prev_flag  (flags[i-1]),
        .prev_entry (entries[i-1]),
        .next_entry (entries[i+1]),
        .flag       (flags[i]),
        .entry      (entries[i]),
        .grant      (grants[i])
      );
    end
  end

  // at most one cell drives a nonzero grant on allocate
  always_comb begin
    grant_or = '0;
    for (int i = 0; i < Depth; i++) begin
      grant_or = grant_or | grants[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, count and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd            <= req.cmd;
      cur_item.size      <= req.region_size;
      cur_item.address   <= req.base_address;
      cur_item.region    <= req.region_number;
      cur_item.job       <= req.owner_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      held_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      // raise valid when a result is loaded, drop it once the result is taken
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= CMP;
          end
        end
        CMP: begin
          state <= ACT;
        end
        ACT: begin
          if (emit) begin
            state <= accept ? CMP : IDLE;
            if (apply) begin
              held_count <= ctl.alloc ? held_count - 1'b1 : held_count + 1'b1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // result payload: loaded when the shift cycle completes
  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctl.alloc) begin
        rsp.status <= any_fit ? ssfp_pkg::STATUS_DONE : ssfp_pkg::STATUS_NOFIT;
      end else begin
        rsp.status <= full ? ssfp_pkg::STATUS_FULL : ssfp_pkg::STATUS_DONE;
      end
      if (ctl.alloc && any_fit) begin
        rsp.granted_size    <= grant_or.size;
        rsp.granted_address <= grant_or.address;
        rsp.granted_region  <= grant_or.region;
        rsp.granted_job     <= grant_or.job;
      end else begin
        rsp.granted_size    <= '0;
        rsp.granted_address <= '0;
        rsp.granted_region  <= '0;
        rsp.granted_job     <= '0;
      end
      if (apply) begin
        rsp.entry_count <= ssfp_pkg::COUNT_W'(ctl.alloc ? held_count - 1'b1
                                                        : held_count + 1'b1);
      end else begin
        rsp.entry_count <= ssfp_pkg::COUNT_W'(held_count);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CountW'(Depth))
    else $error("entry count exceeds pool depth");

  a_single_fit: assert property (@(posedge clk) disable iff (rst)
    (state == ACT && ctl.alloc) |-> $countones(flags & ~{flags[Depth-2:0], 1'b0}) <= 1)
    else $error("more than one first-fit cell on allocate");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (apply && !ctl.alloc) |=> held_count == $past(held_count) + 1'b1)
    else $error("count not advanced on add");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (apply && ctl.alloc) |=> held_count == $past(held_count) - 1'b1)
    else $error("count not reduced on allocate");

  a_no_fit_hold: assert property (@(posedge clk) disable iff (rst)
    (emit && !apply) |=> $stable(held_count))
    else $error("count changed on dropped or unfit request");
`endif

endmodule

`default_nettype wire

[rtl/ssfp_cell.sv]
// One slot of the sorted chain: holds a region, its compare flag, and shifts with neighbors.
// Depends on ssfp_pkg (entry_t, ctl_t).
`default_nettype none

module ssfp_cell (
  input  wire                  clk,
  input  ssfp_pkg::ctl_t       ctl,
  input  wire                  occupied,
  input  wire                  prev_flag,
  input  ssfp_pkg::entry_t     prev_entry,
  input  ssfp_pkg::entry_t     next_entry,
  output logic                 flag,
  output ssfp_pkg::entry_t     entry,
  output ssfp_pkg::entry_t     grant
);

  logic found;

  // Add: flag marks slots holding a strictly larger region (empty slots count as larger).
  // Allocate: flag marks occupied slots that fit the request.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      if (occupied) begin
        flag <= ctl.alloc ? (entry.size >= ctl.item.size) : (entry.size > ctl.item.size);
      end else begin
        flag <= !ctl.alloc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act) begin
      if (ctl.alloc) begin
        // close the gap left by the granted slot
        if (flag) begin
          entry <= next_entry;
        end
      end else begin
        // open a gap at the first larger slot and drop the new region in
        if (prev_flag) begin
          entry <= prev_entry;
        end else if (flag) begin
          entry <= ctl.item;
        end
      end
    end
  end

  // first fitting slot drives its region onto the grant OR
  assign found = flag && !prev_flag;
  assign grant = found ? entry : '0;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for size_sorted_free_region_pool: directed and random add and
// allocate requests, each result checked against a best-fit pool predictor.
// Depends on ssfp_pkg, ssfp_if (ssfp_req_if, ssfp_rsp_if) and the pool RTL.
`default_nettype none

module testbench;
  import ssfp_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int REQUEST_COUNT = 2000;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off that backs up the pool
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 20;    // look for stray results after the last one

  localparam logic [SIZE_W-1:0] SIZE_TOP = '1;

  // One result as it leaves the block
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   address;
    logic [REGION_W-1:0] region;
    logic [JOB_W-1:0]    job;
    logic [COUNT_W-1:0]  count;
  } grant_t;

  // Mirror of the free list plus the results still owed by the block.
  class grant_scoreboard;
    entry_t pool[$];            // free regions, ascending size, arrival order on ties
    grant_t owed_grants[$];     // expected results, oldest first
    int adds, allocs, drops, grants, misses, checked, errors;

    function grant_t predict_grant(logic cmd, entry_t item);
      grant_t g;
      int slot;
      g = '0;
      g.status = STATUS_DONE;
      if (cmd == CMD_ADD) begin
        adds++;
        if (pool.size() >= POOL_DEPTH) begin
          g.status = STATUS_FULL;
          drops++;
        end else begin
          // insert ahead of the first strictly larger entry
          slot = pool.size();
          for (int i = 0; i < pool.size(); i++) begin
            if (pool[i].size > item.size) begin
              slot = i;
              break;
            end
          end
          pool.insert(slot, item);
        end
      end else begin
        allocs++;
        slot = -1;
        for (int i = 0; i < pool.size(); i++) begin
          if (pool[i].size >= item.size) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          g.status = STATUS_NOFIT;
          misses++;
        end else begin
          g.size    = pool[slot].size;
          g.address = pool[slot].address;
          g.region  = pool[slot].region;
          g.job     = pool[slot].job;
          pool.delete(slot);
          grants++;
        end
      end
      g.count = COUNT_W'(pool.size());
      return g;
    endfunction

    function void note_request(logic cmd, entry_t item);
      owed_grants.insert(owed_grants.size(), predict_grant(cmd, item));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      checked++;
      if (owed_grants.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, got %h",
                 $time, got);
        return;
      end
      want = owed_grants.pop_front();
      compare_field("status",          64'(want.status),  64'(got.status));
      compare_field("granted_size",    64'(want.size),    64'(got.size));
      compare_field("granted_address", 64'(want.address), 64'(got.address));
      compare_field("granted_region",  64'(want.region),  64'(got.region));
      compare_field("granted_job",     64'(want.job),     64'(got.job));
      compare_field("entry_count",     64'(want.count),   64'(got.count));
    endfunction

    function int pending();
      return owed_grants.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssfp_req_if req_ch ();
  ssfp_rsp_if rsp_ch ();

  size_sorted_free_region_pool DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  grant_scoreboard sb = new();

  // Idling controls, switched per phase by the stimulus
  bit idle_requests = 1'b1;
  bit idle_results  = 1'b1;
  bit hold_results  = 1'b0;   // one-shot request for a long receiver hold-off
  int sent          = 0;
  int quiet_cycles  = 0;

  always #(HALF_PERIOD) clk = ~clk;

  // Gap lengths: mostly short, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic entry_t random_entry(logic [SIZE_W-1:0] size);
    entry_t e;
    e.size    = size;
    e.address = ADDR_W'({$urandom, $urandom});
    e.region  = REGION_W'($urandom);
    e.job     = JOB_W'($urandom);
    return e;
  endfunction

  // Sizes for freed regions: a coarse palette forces ties so arrival order is
  // exercised, small and full-width values spread the sort, extremes now and then.
  function automatic logic [SIZE_W-1:0] pick_add_size();
    logic [SIZE_W-1:0] s;
    case ($urandom_range(0, 15))
      0:          s = '0;
      1:          s = SIZE_TOP;
      2, 3, 4, 5: s = SIZE_W'($urandom_range(0, 7)) << 12;
      6, 7, 8, 9: s = SIZE_W'($urandom_range(0, 65535));
      default:    s = SIZE_W'({$urandom, $urandom});
    endcase
    return s;
  endfunction

  // Request sizes: mostly just below, at or just above a held entry so the
  // smallest-fit search has real work, plus zero, the top value and noise.
  function automatic logic [SIZE_W-1:0] pick_alloc_size();
    logic [SIZE_W-1:0] s;
    int held;
    held = sb.pool.size();
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = SIZE_TOP;
      2, 3:    s = pick_add_size();
      default: begin
        if (held == 0) begin
          s = pick_add_size();
        end else begin
          s = sb.pool[$urandom_range(0, held - 1)].size;
          case ($urandom_range(0, 2))
            0:       if (s != '0) s = s - 1'b1;
            1:       if (s != SIZE_TOP) s = s + 1'b1;
            default: ;
          endcase
        end
      end
    endcase
    return s;
  endfunction

  // Offer one request and hold it until the pool takes it. Keep valid high into
  // the next request unless a gap is drawn; fill gaps with noise on the payload.
  task automatic offer_request(logic cmd, entry_t item);
    entry_t noise;
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= cmd;
    req_ch.region_size   <= item.size;
    req_ch.base_address  <= item.address;
    req_ch.region_number <= item.region;
    req_ch.owner_job     <= item.job;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    if (idle_requests && $urandom_range(0, 2) == 0) begin
      noise = random_entry(SIZE_W'({$urandom, $urandom}));
      req_ch.valid         <= 1'b0;
      req_ch.cmd           <= 1'($urandom);
      req_ch.region_size   <= noise.size;
      req_ch.base_address  <= noise.address;
      req_ch.region_number <= noise.region;
      req_ch.owner_job     <= noise.job;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Add or allocate at random, leaning toward whichever keeps the pool mid-range.
  task automatic offer_mixed(int n);
    int held;
    bit add;
    for (int i = 0; i < n; i++) begin
      held = sb.pool.size();
      if (held < 8)       add = ($urandom_range(0, 3) != 0);
      else if (held > 56) add = ($urandom_range(0, 3) == 0);
      else                add = 1'($urandom_range(0, 1));
      if (add) offer_request(CMD_ADD, random_entry(pick_add_size()));
      else     offer_request(CMD_ALLOC, random_entry(pick_alloc_size()));
    end
  endtask

  // Add until the pool is full, then push a few more that must be dropped.
  task automatic fill_pool();
    int n;
    n = 0;
    while (sb.pool.size() < POOL_DEPTH && n < 80) begin
      offer_request(CMD_ADD, random_entry(pick_add_size()));
      n++;
    end
    repeat (3) offer_request(CMD_ADD, random_entry(pick_add_size()));
  endtask

  // Allocate until the pool is empty, then ask from the empty pool.
  task automatic drain_pool();
    int n;
    n = 0;
    while (sb.pool.size() > 0 && n < 100) begin
      offer_request(CMD_ALLOC, random_entry(pick_alloc_size()));
      n++;
    end
    repeat (2) offer_request(CMD_ALLOC, random_entry(pick_alloc_size()));
  endtask

  // Track every handshake; note requests before checking results.
  always @(posedge clk) begin : watch_channels
    entry_t offered;
    grant_t seen;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        offered.size    = req_ch.region_size;
        offered.address = req_ch.base_address;
        offered.region  = req_ch.region_number;
        offered.job     = req_ch.owner_job;
        sb.note_request(req_ch.cmd, offered);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.status  = rsp_ch.status;
        seen.size    = rsp_ch.granted_size;
        seen.address = rsp_ch.granted_address;
        seen.region  = rsp_ch.granted_region;
        seen.job     = rsp_ch.granted_job;
        seen.count   = rsp_ch.entry_count;
        sb.check_grant(seen);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: drop ready at random, or for a long stretch when asked to.
  initial begin
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_results && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Request side: reset, directed cases, then random phases.
  initial begin
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= CMD_ADD;
    req_ch.region_size   <= '0;
    req_ch.base_address  <= '0;
    req_ch.region_number <= '0;
    req_ch.owner_job     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Allocate from the empty pool, zero request.
    offer_request(CMD_ALLOC, random_entry('0));
    // Extremes of every field, then a tie on size and a smaller region.
    offer_request(CMD_ADD, entry_t'('1));
    offer_request(CMD_ADD, entry_t'('0));
    offer_request(CMD_ADD, random_entry(SIZE_W'(100)));
    offer_request(CMD_ADD, random_entry(SIZE_W'(100)));
    offer_request(CMD_ADD, random_entry(SIZE_W'(50)));
    offer_request(CMD_ADD, random_entry(SIZE_TOP - 1'b1));
    // Zero request takes the smallest; an exact fit takes the earlier of the tie.
    offer_request(CMD_ALLOC, random_entry('0));
    offer_request(CMD_ALLOC, random_entry(SIZE_W'(100)));
    // Top request fits only the top entry; afterwards nothing fits it.
    offer_request(CMD_ALLOC, entry_t'('1));
    offer_request(CMD_ALLOC, entry_t'('1));
    offer_request(CMD_ALLOC, random_entry(SIZE_TOP - 1'b1));
    // Request between sizes skips the smaller entry.
    offer_request(CMD_ALLOC, random_entry(SIZE_W'(51)));
    offer_request(CMD_ALLOC, random_entry(SIZE_W'(1)));
    offer_request(CMD_ALLOC, random_entry('0));

    // Back up the pool: hold results while requests keep coming.
    idle_requests = 1'b0;
    idle_results  = 1'b0;
    hold_results  = 1'b1;
    offer_mixed(30);

    // Fill to the brim with streaming traffic, drain with random gaps.
    fill_pool();
    idle_requests = 1'b1;
    idle_results  = 1'b1;
    drain_pool();

    while (sent < REQUEST_COUNT) begin
      // each side streams with no idling in one phase in four, drawn apart from the other
      idle_requests = ($urandom_range(0, 3) != 0);
      idle_results  = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       fill_pool();
        1:       drain_pool();
        2: begin
          if ($urandom_range(0, 3) == 0) hold_results = 1'b1;
          offer_mixed($urandom_range(20, 40));
        end
        default: offer_mixed($urandom_range(20, 60));
      endcase
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d adds (%0d dropped on a full pool), %0d allocates",
             sent, sb.adds, sb.drops, sb.allocs);
    $display("%0d allocates granted, %0d found no fit; %0d results checked, %0d mismatches",
             sb.grants, sb.misses, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
